// ----- hw/rtl/motc_pkg.sv -----
// Shared types, constants and character helpers for the markup open-tag counter.
package motc_pkg;

  localparam int NUM_PAT     = 8;
  localparam int NUM_CNT     = 6;
  localparam int MAX_LEN     = 9;
  localparam int POS_BITS    = 4;
  localparam int GROUP_BITS  = 3;
  localparam int OUT_BITS    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Tag names in lower case, right-aligned in the word: character p of a name of
  // length n sits at bits [8*(n-1-p) +: 8].
  localparam logic [8*MAX_LEN-1:0] PAT_STR [NUM_PAT] = '{
    "<text", "<tspan", "<image", "<use", "<clippath", "<mask", "<filter", "<pattern"
  };
  localparam logic [POS_BITS-1:0] PAT_LEN [NUM_PAT] = '{
    4'd5, 4'd6, 4'd6, 4'd4, 4'd9, 4'd5, 4'd7, 4'd8
  };
  // Which reported total each tag name adds to.
  localparam logic [GROUP_BITS-1:0] PAT_GROUP [NUM_PAT] = '{
    3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5
  };

  // Control part of one request as it travels down the chain.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } motc_beat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UC_A && b <= CH_UC_Z) begin
      r = b + CASE_OFS;
    end
    return r;
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_GT) || (b == CH_SLASH) || (b == CH_SPACE) ||
           (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

// ----- hw/rtl/motc_in_if.sv -----
// Input channel: one document byte per request.
interface motc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/motc_out_if.sv -----
// Output channel: the six tag totals of one document per request.
interface motc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] text_count;
  logic [15:0] image_count;
  logic [15:0] use_count;
  logic [15:0] clip_count;
  logic [15:0] filter_count;
  logic [15:0] pattern_count;

  modport source (output valid, output text_count, output image_count, output use_count,
                  output clip_count, output filter_count, output pattern_count,
                  input ready);
  modport sink (input valid, input text_count, input image_count, input use_count,
                input clip_count, input filter_count, input pattern_count,
                output ready);
endinterface

// ----- hw/rtl/motc_cell.sv -----
// One matcher cell: tracks one tag name, keeps its own count, forwards the byte.
module motc_cell
  import motc_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  motc_beat_t                          beat_in,
  input  logic [NUM_PAT-1:0][COUNT_BITS-1:0]  cnt_in,
  output motc_beat_t                          beat_out,
  output logic [NUM_PAT-1:0][COUNT_BITS-1:0]  cnt_out
);

  localparam logic [8*MAX_LEN-1:0] WORD = PAT_STR[CELL_IDX];
  localparam logic [POS_BITS-1:0]  LEN  = PAT_LEN[CELL_IDX];

  logic [POS_BITS-1:0]   pos;
  logic [POS_BITS-1:0]   pos_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_upd;
  logic [POS_BITS-1:0]   cur;
  logic [POS_BITS-1:0]   sel_idx;
  logic [7:0]            want;
  logic                  hit;

  always_comb begin
    cur = pos;
    hit = 1'b0;
    // A full name waits for its delimiter; the byte is then matched afresh.
    if (pos >= LEN) begin
      hit = is_delim(beat_in.data);
      cur = '0;
    end
    sel_idx = LEN - POS_BITS'(1) - cur;
    want    = WORD[{sel_idx, 3'b000} +: 8];
    if (to_lower(beat_in.data) == want) begin
      pos_next = cur + POS_BITS'(1);
    end else begin
      pos_next = (beat_in.data == CH_LT) ? POS_BITS'(1) : '0;
    end
    count_upd = (hit && (count != '1)) ? count + COUNT_BITS'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      count <= '0;
    end else if (advance && beat_in.valid) begin
      if (beat_in.last) begin
        pos   <= '0;
        count <= '0;
      end else begin
        pos   <= pos_next;
        count <= count_upd;
      end
    end
  end

  // The byte and the counts ride along with the valid bit; only valid is reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      beat_out.data <= beat_in.data;
      beat_out.last <= beat_in.last;
      for (int i = 0; i < NUM_PAT; i++) begin
        cnt_out[i] <= (i == CELL_IDX) ? count_upd : cnt_in[i];
      end
    end
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (advance) begin
      beat_out.valid <= beat_in.valid;
    end
  end

endmodule

// ----- hw/rtl/motc_merge.sv -----
// Output stage: sums the per-tag counts into six totals and holds the result.
module motc_merge
  import motc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  motc_beat_t                         beat_in,
  input  logic [NUM_PAT-1:0][COUNT_BITS-1:0] cnt_in,
  output logic                               advance,
  motc_out_if.source                         out_ch
);

  localparam int SUM_BITS = COUNT_BITS + 3;
  localparam logic [SUM_BITS-1:0] LIMIT = (COUNT_BITS >= OUT_BITS) ?
      SUM_BITS'({OUT_BITS{1'b1}}) : SUM_BITS'({COUNT_BITS{1'b1}});

  logic [SUM_BITS-1:0] sums [NUM_CNT];
  logic [OUT_BITS-1:0] totals [NUM_CNT];

  always_comb begin
    for (int g = 0; g < NUM_CNT; g++) begin
      sums[g] = '0;
      for (int k = 0; k < NUM_PAT; k++) begin
        if (PAT_GROUP[k] == GROUP_BITS'(g)) begin
          sums[g] = sums[g] + SUM_BITS'(cnt_in[k]);
        end
      end
      totals[g] = (sums[g] > LIMIT) ? OUT_BITS'(LIMIT) : OUT_BITS'(sums[g]);
    end
  end

  assign advance = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= beat_in.valid && beat_in.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.text_count    <= totals[0];
      out_ch.image_count   <= totals[1];
      out_ch.use_count     <= totals[2];
      out_ch.clip_count    <= totals[3];
      out_ch.filter_count  <= totals[4];
      out_ch.pattern_count <= totals[5];
    end
  end

endmodule

// ----- hw/rtl/markup_open_tag_counter.sv -----
// Top level of the case-insensitive markup open-tag counter.
//
// Usage: a document enters on in_ch one byte per request, with last_byte set
// on its final byte. Eight matcher cells sit in a row, one per tag name
// (text, tspan, image, use, clippath, mask, filter, pattern). Each byte moves
// one cell further whenever the row advances, so cell k sees a byte once it
// has passed the cells before it. Every cell keeps its own match position and
// saturating count. When the final byte passes a cell, the cell hands its
// count down the row and clears itself, so the next document may follow on
// the very next cycle. Throughput is one byte per cycle while out_ch is not
// stalled. One request leaves on out_ch per document once its final byte has
// passed eight cell stages plus the output register, where text+tspan and
// clippath+mask are summed. A name that ends on the final byte is not counted.
// Reset (rst, synchronous) clears all match positions, counts and valid bits.
// While a result waits on out_ch and the receiver stalls, the whole row and
// in_ch.ready hold; otherwise bytes keep flowing while the result waits.
module markup_open_tag_counter
  import motc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  motc_in_if.sink    in_ch,
  motc_out_if.source out_ch
);

  // Stage 0 is the input channel; stage k+1 is the register behind cell k.
  motc_beat_t                         beats [NUM_PAT+1];
  logic [NUM_PAT-1:0][COUNT_BITS-1:0] cnts  [NUM_PAT+1];
  logic                               advance;

  assign beats[0] = '{valid: in_ch.valid, data: in_ch.data_byte, last: in_ch.last_byte};
  assign cnts[0]  = '0;

  // The row only moves when the output register can take what leaves it.
  assign in_ch.ready = advance;

  for (genvar k = 0; k < NUM_PAT; k++) begin : g_cell
    motc_cell #(
      .CELL_IDX   (k),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .beat_in  (beats[k]),
      .cnt_in   (cnts[k]),
      .beat_out (beats[k+1]),
      .cnt_out  (cnts[k+1])
    );
  end

  motc_merge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .beat_in (beats[NUM_PAT]),
    .cnt_in  (cnts[NUM_PAT]),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/markup_open_tag_counter_tb.sv -----
// Self-checking testbench for the markup open-tag counter: random documents, stalls, dense tags.
`timescale 1ns / 1ps

module markup_open_tag_counter_tb;

  // Clock and timing. A short pause of TAIL_CYCLES at the end of the run comes
  // before the final check that every document result has arrived.
  localparam int          CLK_PERIOD   = 12;
  localparam int          RESET_CYCLES = 10;
  localparam int          TAIL_CYCLES  = 20;
  localparam longint      TIMEOUT_NS   = 64'd48_000_000;

  // The counter width used for both the block and the prediction.
  localparam int          TALLY_BITS   = 16;
  localparam int unsigned TALLY_MAX    = (1 << TALLY_BITS) - 1;

  // Amount of random text, and the length of the one long receiver hold-off.
  localparam int          RANDOM_BYTES = 1500;
  localparam int          CHUNK_BYTES  = 200;
  localparam int          LONG_HOLD    = 300;
  localparam int          HOLD_AFTER   = 8;

  // Dense document: long runs of tags back to back, so the shared totals of
  // text and tspan grow well beyond what the random text reaches.
  localparam int          PAIR_REPEATS = 10;
  localparam int          USE_REPEATS  = 12;

  localparam int          NUM_TAGS     = 8;
  localparam int          NUM_GROUPS   = 6;

  localparam logic [7:0]  KEY_LT       = 8'h3C;
  localparam logic [7:0]  KEY_TAB      = 8'h09;
  localparam logic [7:0]  KEY_LF       = 8'h0A;
  localparam logic [7:0]  KEY_CR       = 8'h0D;
  localparam logic [7:0]  NAME_END [6] = '{8'h3E, 8'h2F, 8'h20, KEY_TAB, KEY_LF, KEY_CR};

  // One byte of a document as it waits for the driver.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } doc_byte_t;

  // The six totals that the block reports for one document.
  typedef struct packed {
    logic [15:0] text_count;
    logic [15:0] image_count;
    logic [15:0] use_count;
    logic [15:0] clip_count;
    logic [15:0] filter_count;
    logic [15:0] pattern_count;
  } doc_totals_t;

  logic clk;
  logic rst;

  motc_in_if  in_ch ();
  motc_out_if out_ch ();

  markup_open_tag_counter #(
    .COUNT_BITS(TALLY_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Tag names in lower case with the opening bracket, and the total each one
  // feeds: text and tspan share one, clippath and mask share another.
  string tag_name  [NUM_TAGS] = '{"<text", "<tspan", "<image", "<use",
                                  "<clippath", "<mask", "<filter", "<pattern"};
  int    tag_group [NUM_TAGS] = '{0, 0, 1, 2, 3, 3, 4, 5};

  // Prediction state: how far each name has been matched, and the running totals.
  logic [3:0]  name_progress [NUM_TAGS];
  int unsigned group_total   [NUM_GROUPS];

  doc_byte_t   pending_bytes[$];
  logic [7:0]  doc_buf[$];
  doc_totals_t expected_totals[$];

  bit sender_idle;
  bit recv_idle;
  bit in_fired;
  int send_gap;
  int stall_left;
  int hold_left;
  bit long_hold_done;
  int results_seen;
  int bytes_accepted;
  int random_bytes;
  int mismatch_count;

  initial begin
    foreach (name_progress[k]) name_progress[k] = '0;
    foreach (group_total[g]) group_total[g] = 0;
  end

  // Clock, plus known values on every channel input from time zero.
  initial begin
    clk              = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // A fixed upper bound on the whole run. Even with the longest gaps on both
  // sides for every byte, a correct run stays far below this.
  initial begin
    #(TIMEOUT_NS);
    $display("** markup_open_tag_counter: FAILED **");
    $finish;
  end

  function automatic bit is_name_end(input logic [7:0] b);
    foreach (NAME_END[i]) begin
      if (b == NAME_END[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // The block reports sixteen bits, so a larger total shows as all ones.
  function automatic logic [15:0] clamp_out(input int unsigned v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Advances every matcher by one byte. A name that is complete waits for the
  // next byte, which counts it only when it ends a tag name; that byte is then
  // matched again as an ordinary byte, so only '<' can open a fresh match.
  // Returns 1 with the totals on the final byte of a document, and then
  // forgets the document.
  function automatic bit scan_byte(input logic [7:0] b, input logic fin,
                                   output doc_totals_t res);
    logic [7:0] lc;
    int         p;
    lc  = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
    res = '0;
    for (int k = 0; k < NUM_TAGS; k++) begin
      p = name_progress[k];
      if (p >= tag_name[k].len()) begin
        if (is_name_end(b) && group_total[tag_group[k]] < TALLY_MAX) begin
          group_total[tag_group[k]]++;
        end
        p = 0;
      end
      if (lc == tag_name[k][p]) begin
        p++;
      end else begin
        p = (b == KEY_LT) ? 1 : 0;
      end
      name_progress[k] = p[3:0];
    end
    if (!fin) return 1'b0;
    res.text_count    = clamp_out(group_total[0]);
    res.image_count   = clamp_out(group_total[1]);
    res.use_count     = clamp_out(group_total[2]);
    res.clip_count    = clamp_out(group_total[3]);
    res.filter_count  = clamp_out(group_total[4]);
    res.pattern_count = clamp_out(group_total[5]);
    foreach (name_progress[k]) name_progress[k] = '0;
    foreach (group_total[g]) group_total[g] = 0;
    return 1'b1;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit idle);
    int r;
    if (!idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'h20;
    return c;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    doc_buf = {doc_buf, b};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_buf = {doc_buf, s[i]};
  endtask

  // Hands the document in doc_buf to the driver, last_byte on its final byte.
  task automatic close_document();
    doc_byte_t item;
    foreach (doc_buf[i]) begin
      item.data = doc_buf[i];
      item.fin  = (i == doc_buf.size() - 1);
      pending_bytes = {pending_bytes, item};
    end
    doc_buf.delete();
  endtask

  // Holds the sender until every request has gone in and every result is back.
  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_totals.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_count(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // Driver. A new request is put on the channel at the falling edge once the
  // previous one has been taken, after a random gap. valid is assigned once per
  // edge, so back-to-back requests keep it high without a glitch.
  always @(negedge clk) begin : feed_bytes
    doc_byte_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.last_byte <= nxt.fin;
        send_gap = pick_gap(sender_idle);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver. Random stalls, and once, after a few results, a long hold-off so
  // that a waiting result backs the whole row up and the block stops taking
  // bytes while the driver keeps offering them.
  always @(negedge clk) begin : accept_results
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      hold_left      = LONG_HOLD - 1;
      long_hold_done = 1'b1;
      out_ch.ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap(recv_idle);
    end
  end

  // Monitor. Both channels are sampled at the rising edge. The result side is
  // checked before the byte of the same edge is predicted; a byte can never
  // cause a result on the edge where it is accepted.
  always @(posedge clk) begin : watch_channels
    doc_totals_t want;
    doc_totals_t res;
    if (rst) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_totals.size() == 0) begin
          $error("result with no document waiting: text %0d image %0d use %0d",
                 out_ch.text_count, out_ch.image_count, out_ch.use_count);
          mismatch_count++;
        end else begin
          want = expected_totals.pop_front();
          check_count("text_count",    want.text_count,    out_ch.text_count);
          check_count("image_count",   want.image_count,   out_ch.image_count);
          check_count("use_count",     want.use_count,     out_ch.use_count);
          check_count("clip_count",    want.clip_count,    out_ch.clip_count);
          check_count("filter_count",  want.filter_count,  out_ch.filter_count);
          check_count("pattern_count", want.pattern_count, out_ch.pattern_count);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_accepted++;
        if (scan_byte(in_ch.data_byte, in_ch.last_byte, res)) begin
          expected_totals = {expected_totals, res};
        end
      end
    end
  end

  initial begin : stimulus
    int    seg_count;
    int    kind;
    int    pick;
    int    cut;
    int    chunk_bytes;
    int    chunk_no;
    string nm;
    string pool;

    rst            = 1'b1;
    sender_idle    = 1'b1;
    recv_idle      = 1'b1;
    send_gap       = 0;
    stall_left     = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    results_seen   = 0;
    bytes_accepted = 0;
    random_bytes   = 0;
    mismatch_count = 0;
    pool           = "<textspanimgucolhrf/> ";

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed documents. The first has tags in mixed case followed by each
    // name-ending byte but the space, a doubled bracket in front of a name, and the
    // byte extremes. The second ends a name on its final byte, which must not
    // count. The third ends on the delimiter itself, which must count.
    put_text("<TEXT>");
    put_byte(8'h00);
    put_text("<tSpan/<Use");
    put_byte(KEY_TAB);
    put_text("<MASK");
    put_byte(KEY_LF);
    put_text("<<image");
    put_byte(KEY_CR);
    put_byte(8'hFF);
    close_document();
    put_text("<use");
    close_document();
    put_text("<Filter/");
    close_document();
    put_text("<clipPath <PATTERN>");
    close_document();
    wait_for_drain();

    // Random documents. Most of the text is tag names in random case with a
    // random delimiter after them; some names are cut short or followed by a
    // stray byte, and the rest is noise. Idling changes from chunk to chunk,
    // and now and then the sender waits until the block has emptied.
    chunk_no = 0;
    while (random_bytes < RANDOM_BYTES) begin
      while (pending_bytes.size() > 16) @(posedge clk);
      sender_idle = (chunk_no % 4) != 1;
      recv_idle   = (chunk_no % 4) != 2;
      chunk_bytes = 0;
      while (chunk_bytes < CHUNK_BYTES) begin
        seg_count = $urandom_range(0, 10);
        for (int s = 0; s < seg_count; s++) begin
          kind = $urandom_range(0, 99);
          if (kind < 65) begin
            nm  = tag_name[$urandom_range(0, NUM_TAGS - 1)];
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nm.len() - 1) : nm.len();
            for (int i = 0; i < cut; i++) put_byte(vary_case(nm[i]));
            if ($urandom_range(0, 9) < 8) begin
              put_byte(NAME_END[$urandom_range(0, 5)]);
            end else begin
              put_byte(8'($urandom_range(0, 255)));
            end
          end else if (kind < 80) begin
            put_byte(8'($urandom_range(0, 255)));
          end else if (kind < 92) begin
            pick = $urandom_range(0, pool.len() - 1);
            put_byte(vary_case(pool[pick]));
          end else begin
            put_byte(KEY_LT);
          end
        end
        // Sometimes the document stops right after a complete name.
        if ($urandom_range(0, 3) == 0) begin
          nm = tag_name[$urandom_range(0, NUM_TAGS - 1)];
          for (int i = 0; i < nm.len(); i++) put_byte(vary_case(nm[i]));
        end
        if (doc_buf.size() == 0) put_byte(8'($urandom_range(0, 255)));
        chunk_bytes  += doc_buf.size();
        random_bytes += doc_buf.size();
        close_document();
      end
      if (chunk_no % 3 == 2) wait_for_drain();
      chunk_no++;
    end
    wait_for_drain();

    // One dense document at full rate on both sides: text and tspan back to
    // back feed the same total, then a run of use tags, and a final name that
    // ends on the last byte.
    sender_idle = 1'b0;
    recv_idle   = 1'b0;
    for (int i = 0; i < PAIR_REPEATS; i++) put_text("<text/<tspan/");
    for (int i = 0; i < USE_REPEATS; i++) put_text("<use/");
    put_text("<pattern");
    close_document();
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_totals.size() != 0) begin
      $error("%0d document results never arrived", expected_totals.size());
      mismatch_count++;
    end

    $display("Run covered %0d documents over %0d accepted bytes, %0d of them random text.",
             results_seen, bytes_accepted, random_bytes);
    $display("It included a %0d-cycle output hold-off and a dense run of tags at full rate.",
             LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("** markup_open_tag_counter: PASSED **");
    end else begin
      $display("** markup_open_tag_counter: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/motc_pkg.sv
hw/rtl/motc_in_if.sv
hw/rtl/motc_out_if.sv
hw/rtl/motc_cell.sv
hw/rtl/motc_merge.sv
hw/rtl/markup_open_tag_counter.sv
tb/markup_open_tag_counter_tb.sv
